// ===== src/rgbgd_pkg.sv =====
// Shared types, constants and helper functions for the RGB565 gray dither quantizer.
// Used by every module in src except rgbgd_checker; depends on nothing.
package rgbgd_pkg;

  typedef enum logic [1:0] {
    CFG_FAST_REFRESH = 2'd0,
    CFG_FORCE_MONO   = 2'd1,
    CFG_KEEP_AA      = 2'd2,
    CFG_KERNEL       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KERN_NONE  = 2'd0,
    KERN_BAYER = 2'd1,
    KERN_BLUE  = 2'd2,
    KERN_FLOYD = 2'd3
  } kernel_e;

  typedef enum logic [1:0] {
    PATH_MONO,
    PATH_GRAY4,
    PATH_GRAY16
  } path_e;

  typedef enum logic [1:0] {
    THR_FIXED,
    THR_BAYER,
    THR_MASK
  } thr_sel_e;

  typedef struct packed {
    logic    fast_refresh;
    logic    force_mono;
    logic    keep_antialias;
    kernel_e dither_kernel;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  mask_value;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [7:0]  luma;
  } s1_t;

  typedef struct packed {
    path_e      path;
    thr_sel_e   thr_sel;
    logic [7:0] luma;
    logic [7:0] bayer;
    logic [7:0] noise;
  } s2_t;

  localparam logic [15:0] LUMA_R     = 16'd54;
  localparam logic [15:0] LUMA_G     = 16'd183;
  localparam logic [15:0] LUMA_B     = 16'd19;
  localparam logic [15:0] LUMA_ROUND = 16'd128;
  localparam logic [7:0]  FIXED_THR  = 8'd127;
  localparam logic [7:0]  THR_CAP    = 8'd254;
  localparam logic [7:0]  MONO_LIMIT = 8'd127;
  localparam logic [7:0]  STEP_GRAY4  = 8'd85;
  localparam logic [7:0]  STEP_GRAY16 = 8'd17;
  localparam logic [7:0]  GRAY_WHITE  = 8'd255;
  localparam logic [7:0]  GRAY_BLACK  = 8'd0;

  localparam logic [3:0] BAYER_TAB [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  // Threshold 16*B+8 for the 4x4 Bayer cell at (x mod 4, y mod 4).
  function automatic logic [7:0] bayer_thr(input logic [1:0] x, input logic [1:0] y);
    return {BAYER_TAB[{y, x}], 4'h8};
  endfunction

endpackage

// ===== src/rgbgd_front.sv =====
// First pipeline stage: luma from the RGB565 pixel and mask row and column quotients.
// Depends on rgbgd_pkg.
module rgbgd_front #(
  parameter int MASK_SIDE = 64,
  parameter int QW        = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [15:0]        pixel_i,
  input  logic [11:0]        x_pos_i,
  input  logic [11:0]        y_pos_i,
  input  logic [7:0]         mask_value_i,
  output logic               s1_valid_o,
  input  logic               s1_ready_i,
  output rgbgd_pkg::s1_t     s1_o,
  output logic [QW-1:0]      qx_o,
  output logic [QW-1:0]      qy_o
);

  localparam int SH    = 12 + $clog2(MASK_SIDE);
  localparam int RECIP = (2 ** SH + MASK_SIDE - 1) / MASK_SIDE;
  localparam int PW    = SH + QW;

  logic           valid_q;
  rgbgd_pkg::s1_t s1_q, s1_d;
  logic [QW-1:0]  qx_q, qy_q, qx_d, qy_d;
  logic [7:0]     r8, g8, b8;
  logic [15:0]    luma_sum;
  logic [PW-1:0]  prod_x, prod_y;
  logic           advance;

  assign in_ready_o = !valid_q || s1_ready_i;
  assign advance    = in_valid_i && in_ready_o;

  always_comb begin
    r8 = {pixel_i[15:11], pixel_i[15:13]};
    g8 = {pixel_i[10:5], pixel_i[10:9]};
    b8 = {pixel_i[4:0], pixel_i[4:2]};
    luma_sum = rgbgd_pkg::LUMA_R * {8'd0, r8} + rgbgd_pkg::LUMA_G * {8'd0, g8}
             + rgbgd_pkg::LUMA_B * {8'd0, b8} + rgbgd_pkg::LUMA_ROUND;
    prod_x = PW'(x_pos_i) * PW'(RECIP);
    prod_y = PW'(y_pos_i) * PW'(RECIP);
    qx_d   = prod_x[SH +: QW];
    qy_d   = prod_y[SH +: QW];
    s1_d.mode       = mode_i;
    s1_d.mask_value = mask_value_i;
    s1_d.x_pos      = x_pos_i;
    s1_d.y_pos      = y_pos_i;
    s1_d.luma       = luma_sum[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_o       = s1_q;
  assign qx_o       = qx_q;
  assign qy_o       = qy_q;

endmodule

// ===== src/rgbgd_mask.sv =====
// Second pipeline stage: blue-noise mask store, mask loading and path selection.
// Depends on rgbgd_pkg.
module rgbgd_mask #(
  parameter int MASK_SIDE = 64,
  parameter int QW        = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgbgd_pkg::cfg_t    cfg_i,
  input  logic               s1_valid_i,
  output logic               s1_ready_o,
  input  rgbgd_pkg::s1_t     s1_i,
  input  logic [QW-1:0]      qx_i,
  input  logic [QW-1:0]      qy_i,
  output logic               s2_valid_o,
  input  logic               s2_ready_i,
  output rgbgd_pkg::s2_t     s2_o
);

  localparam int AW    = $clog2(MASK_SIDE);
  localparam int DEPTH = 2 ** (2 * AW);

  logic [7:0]      noise_mask_q [DEPTH];
  logic            valid_q;
  rgbgd_pkg::s2_t  s2_q, s2_d;
  logic [7:0]      noise_q;
  logic [11:0]     rem_x, rem_y;
  logic [2*AW-1:0] addr;
  logic            advance;

  assign s1_ready_o = !valid_q || s2_ready_i;
  assign advance    = s1_valid_i && s1_ready_o;

  always_comb begin
    rem_x = s1_i.x_pos - 12'(qx_i) * 12'(MASK_SIDE);
    rem_y = s1_i.y_pos - 12'(qy_i) * 12'(MASK_SIDE);
    addr  = {rem_y[AW-1:0], rem_x[AW-1:0]};

    s2_d.luma  = s1_i.luma;
    s2_d.bayer = rgbgd_pkg::bayer_thr(s1_i.x_pos[1:0], s1_i.y_pos[1:0]);
    s2_d.noise = '0;
    if (cfg_i.fast_refresh) begin
      s2_d.thr_sel = rgbgd_pkg::THR_BAYER;
      if (cfg_i.force_mono || cfg_i.keep_antialias
          || cfg_i.dither_kernel == rgbgd_pkg::KERN_NONE) begin
        s2_d.path = rgbgd_pkg::PATH_MONO;
      end else begin
        s2_d.path = rgbgd_pkg::PATH_GRAY4;
      end
    end else begin
      s2_d.path = rgbgd_pkg::PATH_GRAY16;
      unique case (cfg_i.dither_kernel)
        rgbgd_pkg::KERN_NONE:  s2_d.thr_sel = rgbgd_pkg::THR_FIXED;
        rgbgd_pkg::KERN_BAYER: s2_d.thr_sel = rgbgd_pkg::THR_BAYER;
        rgbgd_pkg::KERN_BLUE:  s2_d.thr_sel = rgbgd_pkg::THR_MASK;
        rgbgd_pkg::KERN_FLOYD: s2_d.thr_sel = rgbgd_pkg::THR_MASK;
        default:               s2_d.thr_sel = rgbgd_pkg::THR_FIXED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      valid_q <= s1_valid_i && !s1_i.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s1_i.mode) begin
        noise_mask_q[addr] <= s1_i.mask_value;
      end else begin
        s2_q    <= s2_d;
        noise_q <= noise_mask_q[addr];
      end
    end
  end

  always_comb begin
    s2_o       = s2_q;
    s2_o.noise = noise_q;
  end

  assign s2_valid_o = valid_q;

endmodule

// ===== src/rgbgd_quant.sv =====
// Third and fourth pipeline stages: threshold offset, level rounding and output scaling.
// Depends on rgbgd_pkg.
module rgbgd_quant (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s2_valid_i,
  output logic               s2_ready_o,
  input  rgbgd_pkg::s2_t     s2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         gray_o
);

  logic                  v3_q, v4_q;
  logic                  r3, r4;
  logic [11:0]           offs_q, offs_d;
  rgbgd_pkg::path_e      path_q;
  logic                  bright_q;
  logic [7:0]            thr, thr_cap;
  logic [11:0]           scaled;
  logic [11:0]           round_sum;
  logic [3:0]            level;
  logic [7:0]            gray_q, gray_d;

  assign r4         = !v4_q || out_ready_i;
  assign r3         = !v3_q || r4;
  assign s2_ready_o = r3;

  always_comb begin
    unique case (s2_i.thr_sel)
      rgbgd_pkg::THR_FIXED: thr = rgbgd_pkg::FIXED_THR;
      rgbgd_pkg::THR_BAYER: thr = s2_i.bayer;
      rgbgd_pkg::THR_MASK:  thr = s2_i.noise;
      default:              thr = rgbgd_pkg::FIXED_THR;
    endcase
    thr_cap = (thr < rgbgd_pkg::THR_CAP) ? thr : rgbgd_pkg::THR_CAP;
    if (s2_i.path == rgbgd_pkg::PATH_GRAY4) begin
      scaled = {3'd0, s2_i.luma, 1'b0} + {4'd0, s2_i.luma};
    end else begin
      scaled = {s2_i.luma, 4'd0} - {4'd0, s2_i.luma};
    end
    offs_d = scaled + {4'd0, rgbgd_pkg::THR_CAP} - {4'd0, thr_cap};
  end

  always_comb begin
    round_sum = offs_q + {8'd0, offs_q[11:8]} + 12'd1;
    level     = round_sum[11:8];
    unique case (path_q)
      rgbgd_pkg::PATH_MONO:   gray_d = bright_q ? rgbgd_pkg::GRAY_WHITE
                                                : rgbgd_pkg::GRAY_BLACK;
      rgbgd_pkg::PATH_GRAY4:  gray_d = 8'({4'd0, level} * rgbgd_pkg::STEP_GRAY4);
      rgbgd_pkg::PATH_GRAY16: gray_d = 8'({4'd0, level} * rgbgd_pkg::STEP_GRAY16);
      default:                gray_d = rgbgd_pkg::GRAY_BLACK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r3) begin
        v3_q <= s2_valid_i;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_i && r3) begin
      offs_q   <= offs_d;
      path_q   <= s2_i.path;
      bright_q <= s2_i.luma > rgbgd_pkg::MONO_LIMIT;
    end
    if (v3_q && r4) begin
      gray_q <= gray_d;
    end
  end

  assign out_valid_o = v4_q;
  assign gray_o      = gray_q;

endmodule

// ===== src/rgb565_gray_dither_quantizer_top.sv =====
// Top level of the RGB565 to gray ordered-dither quantizer: configuration registers
// and the four-stage pipeline. Depends on rgbgd_pkg, rgbgd_front, rgbgd_mask, rgbgd_quant.
// A pixel transfer passes through the front, mask, offset and output registers to its result.
// Throughput: one item per cycle; each stage holds when its successor is full and stalled.
// Mask load items take one pipeline slot and produce no result.
// Reset clears the valid bits and configuration; the noise mask is not cleared.
module rgb565_gray_dither_quantizer_top #(
  parameter int MASK_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] pixel_i,
  input  logic [11:0] x_pos_i,
  input  logic [11:0] y_pos_i,
  input  logic [7:0]  mask_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  gray_o
);

  localparam int QW = $clog2(4095 / MASK_SIDE + 1);

  rgbgd_pkg::cfg_t cfg_q;
  rgbgd_pkg::s1_t  s1;
  rgbgd_pkg::s2_t  s2;
  logic            s1_valid, s1_ready, s2_valid, s2_ready;
  logic [QW-1:0]   qx, qy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_refresh   <= 1'b0;
      cfg_q.force_mono     <= 1'b0;
      cfg_q.keep_antialias <= 1'b0;
      cfg_q.dither_kernel  <= rgbgd_pkg::KERN_NONE;
    end else if (cfg_we_i) begin
      unique case (rgbgd_pkg::cfg_idx_e'(cfg_idx_i))
        rgbgd_pkg::CFG_FAST_REFRESH: cfg_q.fast_refresh   <= cfg_data_i[0];
        rgbgd_pkg::CFG_FORCE_MONO:   cfg_q.force_mono     <= cfg_data_i[0];
        rgbgd_pkg::CFG_KEEP_AA:      cfg_q.keep_antialias <= cfg_data_i[0];
        rgbgd_pkg::CFG_KERNEL:
          cfg_q.dither_kernel <= rgbgd_pkg::kernel_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  rgbgd_front #(
    .MASK_SIDE (MASK_SIDE),
    .QW        (QW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .pixel_i      (pixel_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .mask_value_i (mask_value_i),
    .s1_valid_o   (s1_valid),
    .s1_ready_i   (s1_ready),
    .s1_o         (s1),
    .qx_o         (qx),
    .qy_o         (qy)
  );

  rgbgd_mask #(
    .MASK_SIDE (MASK_SIDE),
    .QW        (QW)
  ) u_mask (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .qx_i       (qx),
    .qy_i       (qy),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2)
  );

  rgbgd_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_ready_o  (s2_ready),
    .s2_i        (s2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gray_o      (gray_o)
  );

endmodule

// ===== src/rgbgd_checker.sv =====
// Port-level checker for the gray dither quantizer, bound to the top level.
// Depends only on the top level's ports.
module rgbgd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  gray_o
);

  logic [2:0] pending_q;
  logic       pix_xfer, out_xfer;

  assign pix_xfer = in_valid_i && in_ready_o && !mode_i;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + 3'(pix_xfer) - 3'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(gray_o))
    else $error("stalled output transfer changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("output shown with no pixel pending");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more pixels in flight than pipeline stages");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while output side can move");

endmodule

bind rgb565_gray_dither_quantizer_top rgbgd_checker u_rgbgd_checker (.*);

// ===== sim/gray_quant_checker.sv =====
// Checker for the RGB565 gray dither quantizer: it watches the register port and both
// transfer channels, predicts each gray value and compares the results in order.
// Depends on rgbgd_pkg for the register index and kernel codes.
module gray_quant_checker #(
  parameter int   MASK_SIDE = 64,
  parameter logic MODE_LOAD = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [15:0] pixel_i,
  input  logic [11:0] x_pos_i,
  input  logic [11:0] y_pos_i,
  input  logic [7:0]  mask_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  gray_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam logic [63:0] BAYER_RANKS = 64'h5D7F_91B3_6E4C_A280;

  logic                 fast_q;
  logic                 mono_q;
  logic                 antialias_q;
  rgbgd_pkg::kernel_e   kernel_q;
  logic [7:0] noise_copy [MASK_SIDE*MASK_SIDE];
  logic [7:0] expected_gray_q [$];
  int         failures;
  int         checked;

  assign fail_count_o = failures;
  assign pending_o    = expected_gray_q.size();
  assign results_o    = checked;

  initial begin
    fast_q      = 1'b0;
    mono_q      = 1'b0;
    antialias_q = 1'b0;
    kernel_q    = rgbgd_pkg::KERN_NONE;
    failures    = 0;
    checked     = 0;
  end

  function automatic int mask_slot(logic [11:0] x, logic [11:0] y);
    return (int'(y) % MASK_SIDE) * MASK_SIDE + int'(x) % MASK_SIDE;
  endfunction

  function automatic int luma_of_rgb565(logic [15:0] px);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {px[15:11], px[15:13]};
    g = {px[10:5], px[10:9]};
    b = {px[4:0], px[4:2]};
    return (54 * int'(r) + 183 * int'(g) + 19 * int'(b) + 128) >> 8;
  endfunction

  function automatic int bayer_threshold(logic [11:0] x, logic [11:0] y);
    int rank_pos;
    rank_pos = int'({y[1:0], x[1:0]});
    return 16 * int'(BAYER_RANKS[rank_pos*4 +: 4]) + 8;
  endfunction

  function automatic logic [7:0] dither_level(int luma, int thr, int max_level, int step);
    int capped;
    int scaled;
    int level;
    capped = (thr < 254) ? thr : 254;
    scaled = luma * max_level + 254 - capped;
    level  = (scaled + (scaled >> 8) + 1) >> 8;
    return 8'(level * step);
  endfunction

  function automatic logic [7:0] predict_gray(logic [15:0] px, logic [11:0] x, logic [11:0] y);
    int luma;
    int thr;
    luma = luma_of_rgb565(px);
    if (fast_q) begin
      if (mono_q || antialias_q || kernel_q == rgbgd_pkg::KERN_NONE) begin
        return (luma > 127) ? 8'd255 : 8'd0;
      end
      return dither_level(luma, bayer_threshold(x, y), 3, 85);
    end
    case (kernel_q)
      rgbgd_pkg::KERN_NONE:  thr = 127;
      rgbgd_pkg::KERN_BAYER: thr = bayer_threshold(x, y);
      default:               thr = int'(noise_copy[mask_slot(x, y)]);
    endcase
    return dither_level(luma, thr, 15, 17);
  endfunction

  task automatic log_error(string what, int expv, int actv);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s: expected gray %0d, got %0d", $realtime, what, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fast_q      = 1'b0;
      mono_q      = 1'b0;
      antialias_q = 1'b0;
      kernel_q    = rgbgd_pkg::KERN_NONE;
      expected_gray_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (rgbgd_pkg::cfg_idx_e'(cfg_idx_i))
          rgbgd_pkg::CFG_FAST_REFRESH: fast_q = cfg_data_i[0];
          rgbgd_pkg::CFG_FORCE_MONO:   mono_q = cfg_data_i[0];
          rgbgd_pkg::CFG_KEEP_AA:      antialias_q = cfg_data_i[0];
          rgbgd_pkg::CFG_KERNEL:       kernel_q = rgbgd_pkg::kernel_e'(cfg_data_i);
          default:                     ;
        endcase
      end
      // The output side is handled first so that a result can never match the
      // expectation pushed by a transfer in the same cycle.
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_gray_q.size() == 0) begin
          log_error("result with nothing pending", -1, int'(gray_i));
        end else if (expected_gray_q[0] !== gray_i) begin
          log_error("gray mismatch", int'(expected_gray_q[0]), int'(gray_i));
          void'(expected_gray_q.pop_front());
        end else begin
          void'(expected_gray_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == MODE_LOAD) begin
          noise_copy[mask_slot(x_pos_i, y_pos_i)] = mask_value_i;
        end else begin
          expected_gray_q.push_back(predict_gray(pixel_i, x_pos_i, y_pos_i));
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the quantizer testbench: clock, reset, register writes, pixel and mask-load
// stimulus with random sender gaps and receiver stalls, watchdog and verdict.
// Depends on rgbgd_pkg, rgb565_gray_dither_quantizer_top and gray_quant_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   MASK_SIDE      = 64;
  localparam int   RESET_CYCLES   = 9;
  localparam int   SETTLE_CYCLES  = 10;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   PHASE_ITEMS    = 98;
  localparam logic MODE_PIXEL     = 1'b0;
  localparam logic MODE_LOAD      = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = 2'd0;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_PIXEL;
  logic [15:0] pixel = 16'd0;
  logic [11:0] x_pos = 12'd0;
  logic [11:0] y_pos = 12'd0;
  logic [7:0]  mask_value = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  gray;

  int fail_count;
  int pending;
  int results;

  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 stall_style = 0;
  int                 style_left = 0;
  int                 pixels_sent = 0;
  int                 loads_sent = 0;
  int                 settings_run = 0;
  logic               cur_fast = 1'b0;
  rgbgd_pkg::kernel_e cur_kernel = rgbgd_pkg::KERN_NONE;
  bit                 mask_written [MASK_SIDE*MASK_SIDE];
  int                 written_list [$];

  always #2 clk = ~clk;

  rgb565_gray_dither_quantizer_top #(
    .MASK_SIDE(MASK_SIDE)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .pixel_i     (pixel),
    .x_pos_i     (x_pos),
    .y_pos_i     (y_pos),
    .mask_value_i(mask_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .gray_o      (gray)
  );

  gray_quant_checker #(
    .MASK_SIDE(MASK_SIDE),
    .MODE_LOAD(MODE_LOAD)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .mode_i      (mode),
    .pixel_i     (pixel),
    .x_pos_i     (x_pos),
    .y_pos_i     (y_pos),
    .mask_value_i(mask_value),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .gray_i      (gray),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_style <= 0;
      style_left  <= 0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ~out_ready;
        2:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: %0d cycles without a transfer.", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(logic md, logic [15:0] px, logic [11:0] x, logic [11:0] y,
                           logic [7:0] mv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    mode       <= md;
    pixel      <= px;
    x_pos      <= x;
    y_pos      <= y;
    mask_value <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_pixel(logic [15:0] px, logic [11:0] x, logic [11:0] y);
    push_item(MODE_PIXEL, px, x, y, 8'($urandom_range(0, 255)));
    pixels_sent++;
  endtask

  task automatic send_load(logic [11:0] x, logic [11:0] y, logic [7:0] v);
    int slot;
    slot = (int'(y) % MASK_SIDE) * MASK_SIDE + int'(x) % MASK_SIDE;
    push_item(MODE_LOAD, 16'($urandom_range(0, 65535)), x, y, v);
    if (!mask_written[slot]) begin
      mask_written[slot] = 1'b1;
      written_list.push_back(slot);
    end
    loads_sent++;
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(rgbgd_pkg::cfg_idx_e idx, logic [1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(logic fast, logic mono, logic aa, rgbgd_pkg::kernel_e kern);
    drain();
    write_reg(rgbgd_pkg::CFG_FAST_REFRESH, {1'b0, fast});
    write_reg(rgbgd_pkg::CFG_FORCE_MONO, {1'b0, mono});
    write_reg(rgbgd_pkg::CFG_KEEP_AA, {1'b0, aa});
    write_reg(rgbgd_pkg::CFG_KERNEL, kern);
    cfg_we     <= 1'b0;
    cur_fast   = fast;
    cur_kernel = kern;
    settings_run++;
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hF800;
      3:       return 16'h07E0;
      4:       return 16'h001F;
      5:       return 16'h8410;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_pixel();
    int          slot;
    logic [11:0] x;
    logic [11:0] y;
    if (!cur_fast && (cur_kernel == rgbgd_pkg::KERN_BLUE
                      || cur_kernel == rgbgd_pkg::KERN_FLOYD)) begin
      slot = written_list[$urandom_range(0, written_list.size() - 1)];
      x = 12'(slot % MASK_SIDE + MASK_SIDE * $urandom_range(0, 4096 / MASK_SIDE - 1));
      y = 12'(slot / MASK_SIDE + MASK_SIDE * $urandom_range(0, 4096 / MASK_SIDE - 1));
    end else begin
      x = 12'($urandom_range(0, 4095));
      y = 12'($urandom_range(0, 4095));
    end
    send_pixel(pick_pixel(), x, y);
  endtask

  task automatic run_phase(logic fast, logic mono, logic aa, rgbgd_pkg::kernel_e kern);
    set_config(fast, mono, aa, kern);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_load(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  8'($urandom_range(0, 255)));
      end else begin
        random_pixel();
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(1'b0, 1'b0, 1'b0, rgbgd_pkg::KERN_NONE);
    send_load(12'd0, 12'd0, 8'd255);
    send_load(12'd4095, 12'd4095, 8'd0);
    send_load(12'd64, 12'd1, 8'd254);
    send_load(12'd63, 12'd1, 8'd128);
    send_pixel(16'h0000, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'd4095, 12'd4095);
    send_pixel(16'hF800, 12'd1, 12'd2);
    send_pixel(16'h07E0, 12'd2, 12'd3);
    send_pixel(16'h001F, 12'd3, 12'd1);
    send_pixel(16'h8410, 12'd2048, 12'd2048);

    set_config(1'b1, 1'b0, 1'b0, rgbgd_pkg::KERN_BAYER);
    send_pixel(16'hFFFF, 12'd0, 12'd0);
    send_pixel(16'h0000, 12'd3, 12'd3);
    send_pixel(16'h8410, 12'd1, 12'd0);
    send_pixel(16'h7BEF, 12'd2, 12'd3);

    set_config(1'b0, 1'b0, 1'b0, rgbgd_pkg::KERN_BLUE);
    send_pixel(16'hFFFF, 12'd0, 12'd0);
    send_pixel(16'h0000, 12'd4095, 12'd4095);
    send_pixel(16'h8410, 12'd128, 12'd65);
    send_pixel(16'hFFFF, 12'd64, 12'd4033);
    send_pixel(16'h7BEF, 12'd4031, 12'd1);

    run_phase(1'b0, 1'b0, 1'b0, rgbgd_pkg::KERN_NONE);
    run_phase(1'b0, 1'b0, 1'b0, rgbgd_pkg::KERN_BAYER);
    run_phase(1'b0, 1'b0, 1'b0, rgbgd_pkg::KERN_BLUE);
    run_phase(1'b0, 1'b0, 1'b0, rgbgd_pkg::KERN_FLOYD);
    run_phase(1'b1, 1'b0, 1'b0, rgbgd_pkg::KERN_BAYER);
    run_phase(1'b1, 1'b0, 1'b0, rgbgd_pkg::KERN_NONE);
    run_phase(1'b1, 1'b1, 1'b0, rgbgd_pkg::KERN_BAYER);
    run_phase(1'b1, 1'b0, 1'b1, rgbgd_pkg::KERN_BLUE);
    run_phase(1'b1, 1'b1, 1'b1, rgbgd_pkg::KERN_FLOYD);
    run_phase(1'b1, 1'b0, 1'b0, rgbgd_pkg::KERN_FLOYD);
    run_phase(1'b1, 1'b0, 1'b0, rgbgd_pkg::KERN_BLUE);
    run_phase(1'b0, 1'b1, 1'b1, rgbgd_pkg::KERN_BAYER);
    repeat (4) begin
      run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), rgbgd_pkg::kernel_e'($urandom_range(0, 3)));
    end

    drain();
    $display("Covered %0d pixel conversions and %0d mask writes over %0d register settings.",
             pixels_sent, loads_sent, settings_run);
    $display("%0d gray results compared, %0d of them failing.", results, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rgbgd_pkg.sv
src/rgbgd_front.sv
src/rgbgd_mask.sv
src/rgbgd_quant.sv
src/rgb565_gray_dither_quantizer_top.sv
src/rgbgd_checker.sv
sim/gray_quant_checker.sv
sim/testbench.sv
